// ===== rtl/core/longest_palindromic_subsequence_top_macros.svh =====
// Assertion macros used by the checker file of the palindrome block.
`ifndef LONGEST_PALINDROMIC_SUBSEQUENCE_TOP_MACROS_SVH
`define LONGEST_PALINDROMIC_SUBSEQUENCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define LPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define LPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lps_pkg.sv =====
// Shared constants and types of the longest palindromic subsequence block.
`default_nettype none

package lps_pkg;

    // Fixed field widths
    localparam int SYM_W = 8;
    localparam int LEN_W = 8;

    // Default string capacity
    localparam int DEFAULT_MAX_LEN = 128;

    // Control bits of a wave travelling down the cell chain
    typedef struct packed {
        logic valid;  // a wave is present
        logic last;   // wave belongs to the final byte of a string
        logic upd;    // wave updates the column (clear: marker only)
    } wave_ctl_t;

endpackage : lps_pkg

`default_nettype wire

// ===== rtl/core/lps_cell.sv =====
// One cell of the chain: a stored byte, its column entry and the wave register.
`default_nettype none

module lps_cell
    import lps_pkg::*;
#(
    parameter int VAL_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // injection of a new byte at this cell
    input  wire wave_ctl_t        inj,
    input  wire logic [SYM_W-1:0] inj_sym,
    // wave arriving from the cell above
    input  wire wave_ctl_t        in_ctl,
    input  wire logic [SYM_W-1:0] in_sym,
    input  wire logic [VAL_W-1:0] in_below,
    input  wire logic [VAL_W-1:0] in_inner,
    // wave leaving towards the cell below
    output wave_ctl_t             out_ctl,
    output logic      [SYM_W-1:0] out_sym,
    output logic      [VAL_W-1:0] out_below,
    output logic      [VAL_W-1:0] out_inner
);

    logic      [SYM_W-1:0] sym_reg,   sym_next;
    logic      [VAL_W-1:0] col_reg,   col_next;
    wave_ctl_t             ctl_reg,   ctl_next;
    logic      [SYM_W-1:0] osym_reg,  osym_next;
    logic      [VAL_W-1:0] below_reg, below_next;
    logic      [VAL_W-1:0] inner_reg, inner_next;

    logic                  match;
    logic      [VAL_W-1:0] cand;

    // recurrence: matching ends add two to the inner span, else the larger neighbour
    assign match = (in_sym == sym_reg);
    assign cand  = match ? (in_inner + VAL_W'(2))
                         : ((in_below > col_reg) ? in_below : col_reg);

    // next state of the stored byte, the column entry and the outgoing wave
    always_comb begin
        sym_next   = sym_reg;
        col_next   = col_reg;
        ctl_next   = '0;
        osym_next  = in_sym;
        below_next = col_reg;
        inner_next = col_reg;
        if (inj.valid) begin
            ctl_next  = inj;
            osym_next = inj_sym;
            if (inj.upd) begin
                // new byte starts its column here: single-byte span has length one
                sym_next   = inj_sym;
                col_next   = VAL_W'(1);
                below_next = VAL_W'(1);
                inner_next = '0;
            end
        end else if (in_ctl.valid) begin
            ctl_next = in_ctl;
            if (in_ctl.upd) begin
                col_next   = cand;
                below_next = cand;
            end
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sym_reg   <= sym_next;
        col_reg   <= col_next;
        osym_reg  <= osym_next;
        below_reg <= below_next;
        inner_reg <= inner_next;
    end

    assign out_ctl   = ctl_reg;
    assign out_sym   = osym_reg;
    assign out_below = below_reg;
    assign out_inner = inner_reg;

endmodule : lps_cell

`default_nettype wire

// ===== rtl/core/longest_palindromic_subsequence_top.sv =====
// Longest palindromic subsequence engine: a chain of MAX_LEN cells with a result register.
//
// Bytes of a string arrive one word per cycle, and the block takes a new byte in every
// cycle while the string lasts. Byte n is written into cell n, and its column of the
// interval table travels as a wave down the chain to cell 0, one cell per cycle, so the
// waves of successive bytes overlap. Once the flagged last byte is taken, the result
// is carried by the wave from cell n-1 to cell 0 (n = bytes stored), held in one
// pending stage and moved into the output register once that register is free;
// s_ready stays low from the last byte until the result enters the output register, and
// bytes of the next string are then taken at once, even while that result still waits.
// Bytes beyond MAX_LEN are dropped and the result covers the first MAX_LEN bytes; a
// length above 255 shows its low 8 bits. No clearing pass after reset is needed.
`default_nettype none

module longest_palindromic_subsequence_top
    import lps_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [SYM_W-1:0] s_symbol,
    input  wire logic             s_last_symbol,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [LEN_W-1:0] m_palindrome_length
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int VAL_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drain_reg, drain_next;
    logic             pend_reg,  pend_next;
    logic [LEN_W-1:0] pval_reg,  pval_next;
    logic             mval_reg,  mval_next;
    logic [LEN_W-1:0] mlen_reg,  mlen_next;

    logic             accept;
    logic             room;
    logic             finish;
    logic             transfer;
    logic [VAL_W+LEN_W-1:0] res_wide;

    // chain links: index i+1 feeds cell i, index 0 leaves the bottom
    wave_ctl_t        ctl_w   [MAX_LEN+1];
    logic [SYM_W-1:0] sym_w   [MAX_LEN+1];
    logic [VAL_W-1:0] below_w [MAX_LEN+1];
    logic [VAL_W-1:0] inner_w [MAX_LEN+1];
    wave_ctl_t        inj_w   [MAX_LEN];

    assign s_ready = !drain_reg;
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < CNT_W'(MAX_LEN));

    // nothing enters from above the top cell
    assign ctl_w[MAX_LEN]   = '0;
    assign sym_w[MAX_LEN]   = '0;
    assign below_w[MAX_LEN] = '0;
    assign inner_w[MAX_LEN] = '0;

    // cell chain; a byte past capacity that ends the string sends a marker from the top
    for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
        always_comb begin
            inj_w[gi] = '0;
            if (accept && room && (count_reg == CNT_W'(gi))) begin
                inj_w[gi] = '{valid: 1'b1, last: s_last_symbol, upd: 1'b1};
            end else if (accept && !room && s_last_symbol && (gi == MAX_LEN - 1)) begin
                inj_w[gi] = '{valid: 1'b1, last: 1'b1, upd: 1'b0};
            end
        end

        lps_cell #(
            .VAL_W (VAL_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .inj       (inj_w[gi]),
            .inj_sym   (s_symbol),
            .in_ctl    (ctl_w[gi+1]),
            .in_sym    (sym_w[gi+1]),
            .in_below  (below_w[gi+1]),
            .in_inner  (inner_w[gi+1]),
            .out_ctl   (ctl_w[gi]),
            .out_sym   (sym_w[gi]),
            .out_below (below_w[gi]),
            .out_inner (inner_w[gi])
        );
    end

    // final wave of a string leaving cell 0 carries the full-string length
    assign finish   = ctl_w[0].valid && ctl_w[0].last;
    assign res_wide = {{LEN_W{1'b0}}, below_w[0]};
    assign transfer = pend_reg && (!mval_reg || m_ready);

    // byte count, drain flag, pending result and output register
    always_comb begin
        count_next = count_reg;
        drain_next = drain_reg;
        pend_next  = pend_reg;
        pval_next  = pval_reg;
        mval_next  = mval_reg;
        mlen_next  = mlen_reg;
        if (accept) begin
            if (s_last_symbol) begin
                count_next = '0;
                drain_next = 1'b1;
            end else if (room) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (finish) begin
            pend_next = 1'b1;
            pval_next = res_wide[LEN_W-1:0];
        end
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        if (transfer) begin
            pend_next  = 1'b0;
            drain_next = 1'b0;
            mval_next  = 1'b1;
            mlen_next  = pval_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drain_reg <= 1'b0;
            pend_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drain_reg <= drain_next;
            pend_reg  <= pend_next;
            mval_reg  <= mval_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        pval_reg <= pval_next;
        mlen_reg <= mlen_next;
    end

    assign m_valid             = mval_reg;
    assign m_palindrome_length = mlen_reg;

endmodule : longest_palindromic_subsequence_top

`default_nettype wire

// ===== rtl/core/lps_checker.sv =====
// Port-level checker of the palindrome block and its bind to the top level.
`default_nettype none

`include "longest_palindromic_subsequence_top_macros.svh"

module lps_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_symbol,
    input wire logic       s_last_symbol,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_palindrome_length
);

    // a stalled result word holds
    `LPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_palindrome_length), "result word changed while stalled")

    // the input closes after the last byte of a string is taken
    `LPS_ASSERT_NEXT(a_close_after_last, aclk, aresetn, s_valid && s_ready && s_last_symbol,
        !s_ready, "input still open after the last byte")

    // a new result only appears at the end of a drain
    `LPS_ASSERT_NOW(a_result_after_drain, aclk, aresetn, $rose(m_valid),
        $past(!s_ready), "result appeared without a preceding drain")

endmodule : lps_checker

bind longest_palindromic_subsequence_top lps_checker u_lps_checker (.*);

`default_nettype wire

// ===== tb/lps_length_check.sv =====
// Channel monitor for the palindrome block: predicts each string's length and compares.
`timescale 1ns / 1ps

module lps_length_check
    import lps_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic             s_last_symbol,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [LEN_W-1:0] m_palindrome_length,
    output int               mismatch_count,
    output int               lengths_checked,
    output int               lengths_outstanding
);

    // Bytes of the current string and two columns of the interval table:
    // span_prev[i] = L(i, n-1), span_next is the column being built.
    logic [SYM_W-1:0] text_bytes [MAX_LEN];
    int unsigned      span_prev  [MAX_LEN];
    int unsigned      span_next  [MAX_LEN];
    int               stored_len = 0;

    logic [LEN_W-1:0] expected_lengths [$];
    int               errors  = 0;
    int               checked = 0;

    // Append one byte and extend the table by its column, bottom row upwards
    task automatic extend_span_table(input logic [SYM_W-1:0] b);
        int j;
        int i;
        j = stored_len;
        text_bytes[j] = b;
        span_next[j] = 1;
        for (i = j - 1; i >= 0; i--) begin
            if (text_bytes[i] == b) begin
                // empty inner interval when the pair is adjacent
                span_next[i] = (i + 1 <= j - 1) ? span_prev[i + 1] + 2 : 2;
            end else begin
                span_next[i] = (span_next[i + 1] > span_prev[i]) ?
                               span_next[i + 1] : span_prev[i];
            end
        end
        for (i = 0; i <= j; i++)
            span_prev[i] = span_next[i];
        stored_len = j + 1;
    endtask

    always @(posedge aclk) begin
        logic [LEN_W-1:0] want;
        if (!aresetn) begin
            stored_len = 0;
            expected_lengths.delete();
        end else begin
            // input word: bytes beyond capacity are dropped, the flag still closes the string
            if (s_valid && s_ready) begin
                if (stored_len < MAX_LEN)
                    extend_span_table(s_symbol);
                if (s_last_symbol) begin
                    expected_lengths.push_back(LEN_W'(span_prev[0]));
                    stored_len = 0;
                end
            end
            // result word: compare with the oldest predicted length
            if (m_valid && m_ready) begin
                if (expected_lengths.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result word: length %0d, none pending",
                                 $time, m_palindrome_length);
                end else begin
                    want = expected_lengths.pop_front();
                    checked++;
                    if (m_palindrome_length !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] length mismatch: expected %0d, got %0d",
                                     $time, want, m_palindrome_length);
                    end
                end
            end
        end
        mismatch_count      <= errors;
        lengths_checked     <= checked;
        lengths_outstanding <= expected_lengths.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the palindrome block: string stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import lps_pkg::*;

    localparam int MAX_LEN         = DEFAULT_MAX_LEN;
    localparam int LIMIT_CYCLES    = 600000;
    localparam int ITEMS_PER_PHASE = 584;

    typedef enum int {
        TEXT_RANDOM,
        TEXT_NEAR_ALPHABET,
        TEXT_NEAR_PALINDROME,
        TEXT_TWO_SYMBOLS
    } text_style_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic [SYM_W-1:0] s_symbol      = '0;
    logic             s_last_symbol = 1'b0;
    logic             m_ready       = 1'b0;
    wire logic             s_ready;
    wire logic             m_valid;
    wire logic [LEN_W-1:0] m_palindrome_length;

    int mismatch_count;
    int lengths_checked;
    int lengths_outstanding;

    int send_idle_pct    = 15;
    int recv_idle_pct    = 81;
    int cycle_count      = 0;
    int strings_sent     = 0;
    int bytes_sent       = 0;
    int overlong_strings = 0;

    logic [SYM_W-1:0] text_q [$];

    longest_palindromic_subsequence_top #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_symbol           (s_symbol),
        .s_last_symbol      (s_last_symbol),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_palindrome_length(m_palindrome_length)
    );

    lps_length_check #(
        .MAX_LEN(MAX_LEN)
    ) length_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_symbol           (s_symbol),
        .s_last_symbol      (s_last_symbol),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_palindrome_length(m_palindrome_length),
        .mismatch_count     (mismatch_count),
        .lengths_checked    (lengths_checked),
        .lengths_outstanding(lengths_outstanding)
    );

    always #5 aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("longest_palindromic_subsequence_top test failed");
            $finish;
        end
    end

    // Send text_q as one string, one word per byte, flag on the final byte
    task automatic send_text();
        int k;
        for (k = 0; k < text_q.size(); k++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_symbol      <= text_q[k];
            s_last_symbol <= (k == text_q.size() - 1);
            do @(posedge aclk); while (!s_ready);
            if (k < MAX_LEN)
                bytes_sent++;
        end
        strings_sent++;
        if (text_q.size() > MAX_LEN)
            overlong_strings++;
    endtask

    // Fill text_q with a random string of the given length
    task automatic build_text(input int len);
        int               k;
        text_style_t      style;
        logic [SYM_W-1:0] base;
        style = text_style_t'($urandom_range(3));
        base  = SYM_W'($urandom_range(255));
        text_q.delete();
        for (k = 0; k < len; k++) begin
            case (style)
                TEXT_RANDOM:      text_q.push_back(SYM_W'($urandom_range(255)));
                TEXT_TWO_SYMBOLS: text_q.push_back($urandom_range(1) ? base : ~base);
                default:          text_q.push_back(base ^ SYM_W'($urandom_range(3)));
            endcase
        end
        // mirror the front half, then sometimes spoil one byte
        if (style == TEXT_NEAR_PALINDROME) begin
            for (k = 0; k < len / 2; k++)
                text_q[len - 1 - k] = text_q[k];
            if ($urandom_range(1))
                text_q[$urandom_range(len - 1)] = SYM_W'($urandom_range(255));
        end
    endtask

    // Random strings under one idling mix: mostly short, now and then near capacity
    task automatic run_phase(input int send_pct, input int recv_pct);
        int goal;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = bytes_sent + ITEMS_PER_PHASE;
        while (bytes_sent < goal) begin
            if ($urandom_range(59) == 0)
                len = $urandom_range(MAX_LEN + 6, MAX_LEN - 8);
            else
                len = $urandom_range(14, 1);
            build_text(len);
            send_text();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: single bytes at both extremes, adjacent pairs, odd and even palindromes
        text_q = '{8'h00};                             send_text();
        text_q = '{8'hFF};                             send_text();
        text_q = '{8'h00, 8'h00};                      send_text();
        text_q = '{8'h00, 8'hFF};                      send_text();
        text_q = '{8'hA5, 8'h5A, 8'hA5};               send_text();
        text_q = '{8'h01, 8'h02, 8'h03, 8'h02, 8'h01}; send_text();
        text_q = '{8'h55, 8'hAA, 8'hAA, 8'h55};        send_text();
        text_q = '{8'h07, 8'h08, 8'h09, 8'h0A};        send_text();

        // capacity: exactly full, then overflowing so the flagged byte is dropped
        build_text(MAX_LEN);
        send_text();
        build_text(MAX_LEN + 3);
        send_text();

        run_phase(15, 81);
        run_phase(81, 15);
        run_phase(0, 0);
        s_valid <= 1'b0;

        // drain, then give any stray result time to show up
        while (lengths_outstanding != 0)
            @(posedge aclk);
        repeat (MAX_LEN + 16) @(posedge aclk);

        $display("Sent %0d strings (%0d stored bytes, %0d beyond capacity);",
                 strings_sent, bytes_sent, overlong_strings);
        $display("checked %0d lengths over three sender/receiver idling mixes.",
                 lengths_checked);
        if (mismatch_count == 0 && lengths_outstanding == 0) begin
            $display("longest_palindromic_subsequence_top test passed");
        end else begin
            $display("longest_palindromic_subsequence_top test failed");
        end
        $finish;
    end

endmodule

// ===== longest_palindromic_subsequence_top.f =====
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_cell.sv
rtl/core/longest_palindromic_subsequence_top.sv
rtl/core/lps_checker.sv
tb/lps_length_check.sv
tb/tb.sv
